### sv/zsw_pkg.sv
// ----------------------------------------------------------------------------
// zsw_pkg
// Shared constants for the ZIP64 store stream writer.
// ----------------------------------------------------------------------------
package zsw_pkg;

   localparam int MAX_ENTRIES_DEF      = 256;
   localparam int NAME_STORE_BYTES_DEF = 4096;
   localparam int OFFSET_BITS_DEF      = 48;

   localparam logic [31:0] CRC_POLY = 32'hEDB88320;

   localparam logic [31:0] SIG_LOCAL   = 32'h04034b50;
   localparam logic [31:0] SIG_DESC    = 32'h08074b50;
   localparam logic [31:0] SIG_CENTRAL = 32'h02014b50;
   localparam logic [31:0] SIG_EOCD64  = 32'h06064b50;
   localparam logic [31:0] SIG_LOC64   = 32'h07064b50;
   localparam logic [31:0] SIG_EOCD    = 32'h06054b50;

   localparam logic [15:0] VERSION   = 16'd45;
   localparam logic [15:0] GP_FLAGS  = 16'h0808;
   localparam logic [15:0] DOS_DATE  = 16'h0021;
   localparam logic [15:0] ZIP64_TAG = 16'h0001;
   localparam logic [31:0] ALL_ONES  = 32'hFFFFFFFF;

   localparam logic [1:0] KIND_START = 2'd0;
   localparam logic [1:0] KIND_NAME  = 2'd1;
   localparam logic [1:0] KIND_DATA  = 2'd2;
   localparam logic [1:0] KIND_PULL  = 2'd3;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_ORDER = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;
   localparam logic [1:0] ST_OVF   = 2'd3;

endpackage

### sv/zsw_crc8.sv
// ----------------------------------------------------------------------------
// zsw_crc8
// One-byte update of a finished CRC-32 (reflected, IEEE polynomial).
// ----------------------------------------------------------------------------
module zsw_crc8 (
   input  logic [31:0] crc_in,
   input  logic [7:0]  data_in,
   output logic [31:0] crc_out
);

   always_comb begin
      logic [31:0] c;
      c = ~crc_in ^ {24'd0, data_in};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? (zsw_pkg::CRC_POLY ^ (c >> 1)) : (c >> 1);
      end
      crc_out = ~c;
   end

endmodule

### sv/zip64_store_stream_writer.sv
// ----------------------------------------------------------------------------
// zip64_store_stream_writer
// Streams a ZIP64 store-only archive with CRC-32, local headers, descriptors,
// central directory and end records.
// ----------------------------------------------------------------------------
// Name and data requests may follow back to back; each gives one byte, plus 20
// trailing bytes on the last name byte, 24 on the last data byte, or 44 on the
// last name byte of an empty entry, one per cycle while the rsp side accepts.
// An entry start is range-checked in S_CHK, then streams 30 header bytes at one
// per cycle while the rsp side accepts. A pull produces each byte through the
// accept, the entry table read, the dependent name store read and the output load.
// All results pass through one output register; a stalled rsp side holds input.
module zip64_store_stream_writer #(
   parameter int MAX_ENTRIES      = zsw_pkg::MAX_ENTRIES_DEF,
   parameter int NAME_STORE_BYTES = zsw_pkg::NAME_STORE_BYTES_DEF,
   parameter int OFFSET_BITS      = zsw_pkg::OFFSET_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,  // name_length[11:0], entry_size[59:12], byte_in[67:60]
   input  logic [1:0]  req_tuser,  // kind[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,  // out_byte[7:0]
   output logic        rsp_tlast,
   output logic [2:0]  rsp_tuser   // archive_done[0], status[2:1]
);

   localparam int EDW = $clog2(MAX_ENTRIES + 1);
   localparam int TAW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int NAW = $clog2(NAME_STORE_BYTES);
   localparam int NFW = $clog2(NAME_STORE_BYTES + 1);
   localparam int FCW = ((NFW > 12) ? NFW : 12) + 1;
   localparam int CKW = ((OFFSET_BITS > 48) ? OFFSET_BITS : 48) + 3;
   localparam int OB  = OFFSET_BITS;
   localparam int RW  = 48 + 32 + OB + NAW + 12;

   localparam logic [2:0] PH_IDLE  = 3'd0;
   localparam logic [2:0] PH_NAME  = 3'd1;
   localparam logic [2:0] PH_DATA  = 3'd2;
   localparam logic [2:0] PH_TRAIL = 3'd3;
   localparam logic [2:0] PH_DONE  = 3'd4;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_CHK  = 3'd1;
   localparam logic [2:0] S_HDR  = 3'd2;
   localparam logic [2:0] S_EXT  = 3'd3;
   localparam logic [2:0] S_DESC = 3'd4;
   localparam logic [2:0] S_TR1  = 3'd5;
   localparam logic [2:0] S_TR2  = 3'd6;
   localparam logic [2:0] S_TR3  = 3'd7;

   logic [1:0]  in_kind;
   logic [11:0] in_nl;
   logic [47:0] in_sz;
   logic [7:0]  in_byte;
   assign in_kind = req_tuser;
   assign in_nl   = req_tdata[11:0];
   assign in_sz   = req_tdata[59:12];
   assign in_byte = req_tdata[67:60];

   logic [2:0]     seq_ff, seq_in, phase_ff, phase_in;
   logic [4:0]     cnt_ff, cnt_in;
   logic [EDW-1:0] ed_ff, ed_in, te_ff, te_in;
   logic [31:0]    crc_ff, crc_in, crc_next;
   logic [47:0]    left_ff, left_in, cur_sz_ff, cur_sz_in;
   logic [OB-1:0]  ao_ff, ao_in, cb_ff, cb_in, cur_off_ff, cur_off_in;
   logic [OB-1:0]  end_ff, end_in;
   logic [NFW-1:0] fill_ff, fill_in;
   logic [12:0]    tp_ff, tp_in;
   logic [11:0]    cur_nl_ff, cur_nl_in, ncnt_ff, ncnt_in;
   logic [NAW-1:0] cur_start_ff, cur_start_in;
   logic [CKW-1:0] sum_a_ff, sum_a_in, sum_b_ff, sum_b_in, tot;

   logic          out_valid_ff, out_valid_in, out_last_ff, out_last_in;
   logic          out_done_ff, out_done_in;
   logic [7:0]    out_byte_ff, out_byte_in;
   logic [1:0]    out_st_ff, out_st_in;
   logic          out_free, acc, ld;

   logic [RW-1:0]  tbl_mem [MAX_ENTRIES];
   logic [RW-1:0]  tbl_rd_ff, tbl_wdata;
   logic           tbl_we, tbl_re;
   logic [7:0]     name_mem [NAME_STORE_BYTES];
   logic [7:0]     name_rd_ff;
   logic           name_we, name_re;
   logic [NAW-1:0] name_raddr;

   logic [47:0]    r_sz;
   logic [31:0]    r_crc;
   logic [OB-1:0]  r_off;
   logic [NAW-1:0] r_start;
   logic [11:0]    r_nl;
   assign r_nl    = tbl_rd_ff[11:0];
   assign r_start = tbl_rd_ff[12 +: NAW];
   assign r_off   = tbl_rd_ff[12 + NAW +: OB];
   assign r_crc   = tbl_rd_ff[12 + NAW + OB +: 32];
   assign r_sz    = tbl_rd_ff[12 + NAW + OB + 32 +: 48];

   logic [239:0] lh_vec;
   logic [159:0] ext_vec;
   logic [191:0] desc_vec;
   logic [367:0] ch_vec;
   logic [223:0] cx_vec;
   logic [783:0] eo_vec;
   logic [15:0]  ed_clip;
   logic [31:0]  cb_clip;
   logic [12:0]  p2;
   logic [7:0]   trail_byte;
   logic         in_entry;

   zsw_crc8 u_crc (
      .crc_in  (crc_ff),
      .data_in (in_byte),
      .crc_out (crc_next)
   );

   assign lh_vec = {16'd20, 4'd0, cur_nl_ff, zsw_pkg::ALL_ONES, zsw_pkg::ALL_ONES, 32'd0,
                    zsw_pkg::DOS_DATE, 32'd0, zsw_pkg::GP_FLAGS, zsw_pkg::VERSION,
                    zsw_pkg::SIG_LOCAL};
   assign ext_vec  = {16'd0, cur_sz_ff, 16'd0, cur_sz_ff, 16'd16, zsw_pkg::ZIP64_TAG};
   assign desc_vec = {16'd0, cur_sz_ff, 16'd0, cur_sz_ff, crc_ff, zsw_pkg::SIG_DESC};
   assign ch_vec = {zsw_pkg::ALL_ONES, 80'd0, 16'd28, 4'd0, r_nl, zsw_pkg::ALL_ONES,
                    zsw_pkg::ALL_ONES, r_crc, zsw_pkg::DOS_DATE, 32'd0, zsw_pkg::GP_FLAGS,
                    zsw_pkg::VERSION, zsw_pkg::VERSION, zsw_pkg::SIG_CENTRAL};
   assign cx_vec = {64'(r_off), 16'd0, r_sz, 16'd0, r_sz, 16'd24, zsw_pkg::ZIP64_TAG};
   assign ed_clip = (64'(ed_ff) < 64'hFFFF) ? 16'(ed_ff) : 16'hFFFF;
   assign cb_clip = (64'(cb_ff) < 64'hFFFFFFFF) ? 32'(cb_ff) : zsw_pkg::ALL_ONES;
   assign eo_vec = {16'd0, zsw_pkg::ALL_ONES, cb_clip, ed_clip, ed_clip, 32'd0,
                    zsw_pkg::SIG_EOCD, 32'd1, 64'(end_ff), 32'd0, zsw_pkg::SIG_LOC64,
                    64'(ao_ff), 64'(cb_ff), 64'(ed_ff), 64'(ed_ff), 64'd0,
                    zsw_pkg::VERSION, zsw_pkg::VERSION, 64'd44, zsw_pkg::SIG_EOCD64};

   assign in_entry = te_ff < ed_ff;
   assign p2       = tp_ff - 13'd46 - {1'b0, r_nl};
   assign tot      = sum_a_ff + sum_b_ff;

   always_comb begin
      if (in_entry) begin
         if (tp_ff < 13'd46) begin
            trail_byte = ch_vec[{tp_ff[5:0], 3'b000} +: 8];
         end else if (tp_ff < 13'd46 + {1'b0, r_nl}) begin
            trail_byte = name_rd_ff;
         end else begin
            trail_byte = cx_vec[{p2[4:0], 3'b000} +: 8];
         end
      end else begin
         trail_byte = eo_vec[{tp_ff[6:0], 3'b000} +: 8];
      end
   end

   assign out_free   = !out_valid_ff || rsp_tready;
   assign req_tready = (seq_ff == S_IDLE) && out_free;
   assign acc        = req_tvalid && req_tready;

   assign tbl_wdata  = {cur_sz_ff, crc_ff, cur_off_ff, cur_start_ff, cur_nl_ff};
   assign name_raddr = r_start + NAW'(tp_ff - 13'd46);

   always_comb begin
      seq_in = seq_ff;  phase_in = phase_ff;  cnt_in = cnt_ff;
      ed_in = ed_ff;  te_in = te_ff;  tp_in = tp_ff;  crc_in = crc_ff;
      left_in = left_ff;  cur_sz_in = cur_sz_ff;  ao_in = ao_ff;  cb_in = cb_ff;
      cur_off_in = cur_off_ff;  end_in = end_ff;  fill_in = fill_ff;
      cur_nl_in = cur_nl_ff;  ncnt_in = ncnt_ff;  cur_start_in = cur_start_ff;
      sum_a_in = sum_a_ff;  sum_b_in = sum_b_ff;
      ld = 1'b0;  out_byte_in = 8'd0;  out_last_in = 1'b1;  out_done_in = 1'b0;
      out_st_in = zsw_pkg::ST_OK;
      tbl_we = 1'b0;  tbl_re = 1'b0;  name_we = 1'b0;  name_re = 1'b0;

      unique case (seq_ff)
         S_IDLE: begin
            if (acc) begin
               ld = 1'b1;
               unique case (in_kind)
                  zsw_pkg::KIND_START: begin
                     ld = 1'b0;
                     if (phase_ff != PH_IDLE || in_nl == 12'd0) begin
                        ld = 1'b1;  out_st_in = zsw_pkg::ST_ORDER;
                     end else if (ed_ff >= EDW'(MAX_ENTRIES) ||
                                  FCW'(fill_ff) + FCW'(in_nl) > FCW'(NAME_STORE_BYTES)) begin
                        ld = 1'b1;  out_st_in = zsw_pkg::ST_FULL;
                     end else begin
                        sum_a_in  = CKW'(ao_ff) + CKW'(cb_ff);
                        sum_b_in  = CKW'(in_sz) + CKW'({in_nl, 1'b0}) + CKW'(246);
                        cur_nl_in = in_nl;
                        cur_sz_in = in_sz;
                        seq_in    = S_CHK;
                     end
                  end
                  zsw_pkg::KIND_NAME: begin
                     if (phase_ff != PH_NAME || fill_ff >= NFW'(NAME_STORE_BYTES)) begin
                        out_st_in = zsw_pkg::ST_ORDER;
                     end else begin
                        name_we     = 1'b1;
                        out_byte_in = in_byte;
                        fill_in     = fill_ff + 1'b1;
                        ao_in       = ao_ff + 1'b1;
                        ncnt_in     = ncnt_ff + 1'b1;
                        if (ncnt_ff + 12'd1 == cur_nl_ff) begin
                           out_last_in = 1'b0;
                           seq_in      = S_EXT;
                           cnt_in      = 5'd0;
                        end
                     end
                  end
                  zsw_pkg::KIND_DATA: begin
                     if (phase_ff != PH_DATA) begin
                        out_st_in = zsw_pkg::ST_ORDER;
                     end else begin
                        crc_in      = crc_next;
                        out_byte_in = in_byte;
                        ao_in       = ao_ff + 1'b1;
                        left_in     = left_ff - 1'b1;
                        if (left_ff == 48'd1) begin
                           out_last_in = 1'b0;
                           seq_in      = S_DESC;
                           cnt_in      = 5'd0;
                        end
                     end
                  end
                  zsw_pkg::KIND_PULL: begin
                     if (phase_ff == PH_IDLE || phase_ff == PH_TRAIL) begin
                        ld       = 1'b0;
                        phase_in = PH_TRAIL;
                        seq_in   = S_TR1;
                     end else begin
                        out_st_in = zsw_pkg::ST_ORDER;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_CHK: begin
            if (out_free) begin
               if (|tot[CKW-1:OB]) begin
                  ld        = 1'b1;
                  out_st_in = zsw_pkg::ST_OVF;
                  seq_in    = S_IDLE;
               end else begin
                  cur_off_in   = ao_ff;
                  cur_start_in = NAW'(fill_ff);
                  crc_in       = 32'd0;
                  left_in      = cur_sz_ff;
                  ncnt_in      = 12'd0;
                  ao_in        = ao_ff + OB'(30);
                  phase_in     = PH_NAME;
                  seq_in       = S_HDR;
                  cnt_in       = 5'd0;
               end
            end
         end
         S_HDR: begin
            if (out_free) begin
               ld          = 1'b1;
               out_byte_in = lh_vec[{cnt_ff, 3'b000} +: 8];
               out_last_in = (cnt_ff == 5'd29);
               cnt_in      = cnt_ff + 1'b1;
               if (cnt_ff == 5'd29) seq_in = S_IDLE;
            end
         end
         S_EXT: begin
            if (out_free) begin
               ld          = 1'b1;
               out_byte_in = ext_vec[{cnt_ff, 3'b000} +: 8];
               out_last_in = 1'b0;
               cnt_in      = cnt_ff + 1'b1;
               if (cnt_ff == 5'd19) begin
                  ao_in  = ao_ff + OB'(20);
                  cnt_in = 5'd0;
                  if (left_ff == 48'd0) begin
                     seq_in = S_DESC;
                  end else begin
                     out_last_in = 1'b1;
                     phase_in    = PH_DATA;
                     seq_in      = S_IDLE;
                  end
               end
            end
         end
         S_DESC: begin
            if (out_free) begin
               ld          = 1'b1;
               out_byte_in = desc_vec[{cnt_ff, 3'b000} +: 8];
               out_last_in = (cnt_ff == 5'd23);
               cnt_in      = cnt_ff + 1'b1;
               if (cnt_ff == 5'd23) begin
                  tbl_we   = 1'b1;
                  ed_in    = ed_ff + 1'b1;
                  ao_in    = ao_ff + OB'(24);
                  cb_in    = cb_ff + OB'(74) + OB'(cur_nl_ff);
                  phase_in = PH_IDLE;
                  seq_in   = S_IDLE;
               end
            end
         end
         S_TR1: begin
            tbl_re = 1'b1;
            end_in = ao_ff + cb_ff;
            seq_in = S_TR2;
         end
         S_TR2: begin
            name_re = 1'b1;
            seq_in  = S_TR3;
         end
         S_TR3: begin
            if (out_free) begin
               ld          = 1'b1;
               out_byte_in = trail_byte;
               seq_in      = S_IDLE;
               tp_in       = tp_ff + 1'b1;
               if (in_entry) begin
                  if (tp_ff + 13'd1 >= 13'd74 + {1'b0, r_nl}) begin
                     te_in = te_ff + 1'b1;
                     tp_in = 13'd0;
                  end
               end else if (tp_ff + 13'd1 >= 13'd98) begin
                  out_done_in = 1'b1;
                  phase_in    = PH_DONE;
               end
            end
         end
         default: ;
      endcase

      if (ld) begin
         out_valid_in = 1'b1;
      end else begin
         out_valid_in = out_valid_ff && !rsp_tready;
      end
   end

   always_ff @(posedge clock) begin
      if (tbl_we) tbl_mem[ed_ff[TAW-1:0]] <= tbl_wdata;
      if (tbl_re) tbl_rd_ff <= tbl_mem[te_ff[TAW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (name_we) name_mem[fill_ff[NAW-1:0]] <= in_byte;
      if (name_re) name_rd_ff <= name_mem[name_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff       <= S_IDLE;
         phase_ff     <= PH_IDLE;
         cnt_ff       <= 5'd0;
         ed_ff        <= '0;
         te_ff        <= '0;
         tp_ff        <= 13'd0;
         crc_ff       <= 32'd0;
         left_ff      <= 48'd0;
         ao_ff        <= '0;
         cb_ff        <= '0;
         fill_ff      <= '0;
         ncnt_ff      <= 12'd0;
         out_valid_ff <= 1'b0;
      end else begin
         seq_ff       <= seq_in;
         phase_ff     <= phase_in;
         cnt_ff       <= cnt_in;
         ed_ff        <= ed_in;
         te_ff        <= te_in;
         tp_ff        <= tp_in;
         crc_ff       <= crc_in;
         left_ff      <= left_in;
         ao_ff        <= ao_in;
         cb_ff        <= cb_in;
         fill_ff      <= fill_in;
         ncnt_ff      <= ncnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_sz_ff    <= cur_sz_in;
      cur_nl_ff    <= cur_nl_in;
      cur_off_ff   <= cur_off_in;
      cur_start_ff <= cur_start_in;
      end_ff       <= end_in;
      sum_a_ff     <= sum_a_in;
      sum_b_ff     <= sum_b_in;
      if (ld) begin
         out_byte_ff <= out_byte_in;
         out_last_ff <= out_last_in;
         out_done_ff <= out_done_in;
         out_st_ff   <= out_st_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_byte_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = {out_st_ff, out_done_ff};

endmodule

### tb/zip64_store_stream_writer_test.sv
// ----------------------------------------------------------------------------
// zip64_store_stream_writer_test
// Self-checking bench for the ZIP64 store stream writer. Requests are driven
// through directed error and boundary cases, random entries mixed with
// out-of-order noise under sender and receiver stalls, and a complete trailer
// read-out. Every response byte is checked against an in-bench archive predictor.
// ----------------------------------------------------------------------------
module zip64_store_stream_writer_test;
   import zsw_pkg::*;

   typedef enum int {PH_IDLE, PH_NAME, PH_DATA, PH_TRAIL, PH_DONE} zip_phase_t;

   typedef struct {
      logic [7:0] out_byte;
      logic       last;
      logic       archive_done;
      logic [1:0] status;
   } zip_byte_t;

   // every entry costs about 76 trailer pulls, so the entry count stays small
   localparam int ENTRY_CAP = 3;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [71:0] req_tdata = '0;
   logic [1:0]  req_tuser = KIND_START;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   logic        rsp_tlast;
   logic [2:0]  rsp_tuser;

   zip64_store_stream_writer u_top (.*);

   always #5 clock = ~clock;

   // archive model state
   logic [47:0] ent_size[MAX_ENTRIES_DEF];
   logic [31:0] ent_crc[MAX_ENTRIES_DEF];
   logic [47:0] ent_offset[MAX_ENTRIES_DEF];
   int          ent_name_at[MAX_ENTRIES_DEF];
   int          ent_name_len[MAX_ENTRIES_DEF];
   logic [7:0]  name_mem[NAME_STORE_BYTES_DEF];
   int          n_entries = 0;
   zip_phase_t  zphase = PH_IDLE;
   logic [31:0] crc_acc = '0;
   logic [47:0] data_left = '0;
   logic [63:0] arc_offset = '0;
   logic [63:0] dir_bytes = '0;
   int          name_fill = 0;
   int          dir_entry = 0;
   int          dir_pos = 0;
   logic [7:0]  blk[98];

   zip_byte_t   archive_q[$];
   int          errors = 0;
   int          n_requests = 0;
   int          n_checked = 0;
   int          n_rejects = 0;
   int          send_idle_pct = 0;
   int          rsp_stall_pct = 0;

   function automatic void put_le(int at, logic [63:0] v, int n);
      for (int i = 0; i < n; i++) blk[at + i] = v[8*i +: 8];
   endfunction

   function automatic void clear_blk();
      for (int i = 0; i < 98; i++) blk[i] = 8'h00;
   endfunction

   function automatic void push_byte(logic [7:0] b, logic done);
      zip_byte_t r;
      r.out_byte = b; r.last = 1'b0; r.archive_done = done; r.status = ST_OK;
      archive_q.push_back(r);
   endfunction

   function automatic void push_blk(int n);
      for (int i = 0; i < n; i++) push_byte(blk[i], 1'b0);
   endfunction

   function automatic logic [31:0] crc32_next(logic [31:0] crc, logic [7:0] b);
      logic [31:0] c;
      c = ~crc ^ {24'h0, b};
      for (int k = 0; k < 8; k++) c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
      return ~c;
   endfunction

   function automatic void close_entry(int cur);
      ent_crc[cur] = crc_acc;
      clear_blk();
      put_le(0, SIG_DESC, 4);
      put_le(4, crc_acc, 4);
      put_le(8, ent_size[cur], 8);
      put_le(16, ent_size[cur], 8);
      push_blk(24);
      arc_offset += 24;
      dir_bytes += 74 + ent_name_len[cur];
      n_entries++;
      zphase = PH_IDLE;
   endfunction

   function automatic logic [7:0] dir_byte();
      int p, nl;
      p = dir_pos;
      clear_blk();
      if (dir_entry < n_entries) begin
         nl = ent_name_len[dir_entry];
         if (p < 46) begin
            put_le(0, SIG_CENTRAL, 4);
            put_le(4, VERSION, 2);
            put_le(6, VERSION, 2);
            put_le(8, GP_FLAGS, 2);
            put_le(14, DOS_DATE, 2);
            put_le(16, ent_crc[dir_entry], 4);
            put_le(20, ALL_ONES, 4);
            put_le(24, ALL_ONES, 4);
            put_le(28, nl, 2);
            put_le(30, 28, 2);
            put_le(42, ALL_ONES, 4);
            return blk[p];
         end
         if (p < 46 + nl) return name_mem[ent_name_at[dir_entry] + p - 46];
         p -= 46 + nl;
         put_le(0, ZIP64_TAG, 2);
         put_le(2, 24, 2);
         put_le(4, ent_size[dir_entry], 8);
         put_le(12, ent_size[dir_entry], 8);
         put_le(20, ent_offset[dir_entry], 8);
         return blk[p];
      end
      put_le(0, SIG_EOCD64, 4);
      put_le(4, 44, 8);
      put_le(12, VERSION, 2);
      put_le(14, VERSION, 2);
      put_le(24, n_entries, 8);
      put_le(32, n_entries, 8);
      put_le(40, dir_bytes, 8);
      put_le(48, arc_offset, 8);
      put_le(56, SIG_LOC64, 4);
      put_le(64, arc_offset + dir_bytes, 8);
      put_le(72, 1, 4);
      put_le(76, SIG_EOCD, 4);
      put_le(84, n_entries < 'hFFFF ? n_entries : 'hFFFF, 2);
      put_le(86, n_entries < 'hFFFF ? n_entries : 'hFFFF, 2);
      put_le(88, dir_bytes < 64'hFFFFFFFF ? dir_bytes : 64'hFFFFFFFF, 4);
      put_le(92, ALL_ONES, 4);
      return blk[p];
   endfunction

   function automatic logic [1:0] predict_request(logic [1:0] kind, int nl,
                                                  logic [47:0] sz, logic [7:0] b);
      logic [63:0] total;
      logic [7:0]  ob;
      logic        done;
      int          cur;
      cur = n_entries;
      case (kind)
         KIND_START: begin
            if (zphase != PH_IDLE || nl == 0) return ST_ORDER;
            if (n_entries >= MAX_ENTRIES_DEF || name_fill + nl > NAME_STORE_BYTES_DEF)
               return ST_FULL;
            total = arc_offset + 74 + nl + sz + dir_bytes + 74 + nl + 98;
            if (total > 64'hFFFF_FFFF_FFFF) return ST_OVF;
            ent_size[cur] = sz;
            ent_offset[cur] = arc_offset;
            ent_name_at[cur] = name_fill;
            ent_name_len[cur] = nl;
            crc_acc = '0;
            data_left = sz;
            clear_blk();
            put_le(0, SIG_LOCAL, 4);
            put_le(4, VERSION, 2);
            put_le(6, GP_FLAGS, 2);
            put_le(12, DOS_DATE, 2);
            put_le(18, ALL_ONES, 4);
            put_le(22, ALL_ONES, 4);
            put_le(26, nl, 2);
            put_le(28, 20, 2);
            push_blk(30);
            arc_offset += 30;
            zphase = PH_NAME;
         end
         KIND_NAME: begin
            if (zphase != PH_NAME || name_fill >= NAME_STORE_BYTES_DEF) return ST_ORDER;
            name_mem[name_fill] = b;
            name_fill++;
            push_byte(b, 1'b0);
            arc_offset += 1;
            if (name_fill - ent_name_at[cur] >= ent_name_len[cur]) begin
               clear_blk();
               put_le(0, ZIP64_TAG, 2);
               put_le(2, 16, 2);
               put_le(4, ent_size[cur], 8);
               put_le(12, ent_size[cur], 8);
               push_blk(20);
               arc_offset += 20;
               if (data_left == 0) close_entry(cur);
               else zphase = PH_DATA;
            end
         end
         KIND_DATA: begin
            if (zphase != PH_DATA || data_left == 0) return ST_ORDER;
            crc_acc = crc32_next(crc_acc, b);
            push_byte(b, 1'b0);
            arc_offset += 1;
            data_left--;
            if (data_left == 0) close_entry(cur);
         end
         default: begin
            if (zphase == PH_IDLE) begin
               zphase = PH_TRAIL;
               dir_entry = 0;
               dir_pos = 0;
            end
            if (zphase != PH_TRAIL) return ST_ORDER;
            ob = dir_byte();
            done = 1'b0;
            dir_pos++;
            if (dir_entry < n_entries) begin
               if (dir_pos >= 74 + ent_name_len[dir_entry]) begin
                  dir_entry++;
                  dir_pos = 0;
               end
            end else if (dir_pos >= 98) begin
               done = 1'b1;
               zphase = PH_DONE;
            end
            push_byte(ob, done);
         end
      endcase
      return ST_OK;
   endfunction

   task automatic send_request(logic [1:0] kind, int nl, logic [47:0] sz, logic [7:0] b);
      zip_byte_t rej;
      logic [1:0] st;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tuser = kind;
      req_tdata = {4'h0, b, sz, nl[11:0]};
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      st = predict_request(kind, nl, sz, b);
      if (st != ST_OK) begin
         rej.out_byte = 8'h00; rej.last = 1'b1; rej.archive_done = 1'b0; rej.status = st;
         archive_q.push_back(rej);
         n_rejects++;
      end else begin
         archive_q[archive_q.size() - 1].last = 1'b1;
      end
      n_requests++;
      @(negedge clock);
      req_tvalid = 1'b0;
   endtask

   task automatic wait_drained();
      while (archive_q.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_noise(bit allow_pull);
      logic [1:0]  k;
      logic [47:0] sz;
      k = allow_pull ? 2'($urandom_range(3)) : 2'($urandom_range(2));
      sz = 48'({$urandom, $urandom});
      if (k == KIND_START && zphase == PH_IDLE)
         send_request(k, $urandom_range(1) ? 0 : $urandom_range(4095),
                      48'hFFFF_FFFF_FFFF - 48'($urandom_range(200)), 8'($urandom));
      else
         send_request(k, $urandom_range(4095), sz, 8'($urandom));
   endtask

   task automatic test_directed();
      send_request(KIND_NAME, 0, 0, 8'h5A);
      send_request(KIND_DATA, 0, 0, 8'hA5);
      send_request(KIND_START, 0, 0, 0);
      send_request(KIND_START, 4095, 48'hFFFF_FFFF_FFFF, 0);
      send_request(KIND_START, 1, 0, 0);           // empty entry
      send_request(KIND_NAME, 0, 0, 8'hFF);
      send_request(KIND_START, 2, 3, 0);
      send_request(KIND_START, 1, 1, 0);
      send_request(KIND_DATA, 0, 0, 8'h11);
      send_request(KIND_PULL, 0, 0, 0);
      send_request(KIND_NAME, 0, 0, 8'h00);
      send_request(KIND_NAME, 0, 0, 8'h80);
      send_request(KIND_NAME, 0, 0, 8'h7F);
      send_request(KIND_PULL, 0, 0, 0);
      send_request(KIND_START, 1, 0, 0);
      send_request(KIND_DATA, 0, 0, 8'h00);
      send_request(KIND_DATA, 0, 0, 8'hFF);
      send_request(KIND_DATA, 0, 0, 8'hA5);
      send_request(KIND_START, 4095, 0, 0);        // name store full
   endtask

   task automatic test_random_entries(int n_req, int idle, int stall, bit hold_off);
      int start;
      start = n_requests;
      send_idle_pct = idle;
      rsp_stall_pct = stall;
      while (n_requests - start < n_req) begin
         if (hold_off && n_requests - start == n_req / 2) wait_drained();
         case (zphase)
            PH_IDLE:
               if (n_entries < ENTRY_CAP && $urandom_range(99) < 85)
                  send_request(KIND_START, $urandom_range(1, 4),
                               48'($urandom_range(40, 60)), 0);
               else send_noise(1'b0);
            PH_NAME:
               if ($urandom_range(99) < 90) send_request(KIND_NAME, 0, 0, 8'($urandom));
               else send_noise(1'b1);
            default:
               if ($urandom_range(99) < 90) send_request(KIND_DATA, 0, 0, 8'($urandom));
               else send_noise(1'b1);
         endcase
      end
   endtask

   task automatic test_close_entry();
      send_idle_pct = 9;
      rsp_stall_pct = 9;
      while (zphase == PH_NAME) send_request(KIND_NAME, 0, 0, 8'($urandom));
      while (zphase == PH_DATA) send_request(KIND_DATA, 0, 0, 8'($urandom));
   endtask

   task automatic test_trailer();
      int k;
      k = 0;
      while (zphase != PH_DONE) begin
         case ((k / 80) % 4)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 70; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 70; end
            default: begin send_idle_pct = 9; rsp_stall_pct = 9; end
         endcase
         send_request(KIND_PULL, 0, 0, 0);
         k++;
      end
      send_request(KIND_PULL, 0, 0, 0);
      send_request(KIND_START, 1, 0, 0);
      send_request(KIND_NAME, 0, 0, 8'h33);
   endtask

   always @(negedge clock) rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);

   always @(posedge clock) begin
      zip_byte_t e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (archive_q.size() == 0) begin
            $display("%0t: unexpected response byte %h last %b user %h",
                     $time, rsp_tdata, rsp_tlast, rsp_tuser);
            errors++;
         end else begin
            e = archive_q.pop_front();
            n_checked++;
            if (rsp_tdata !== e.out_byte || rsp_tlast !== e.last ||
                rsp_tuser !== {e.status, e.archive_done}) begin
               $display("%0t: mismatch exp byte %h last %b done %b st %0d, got %h %b %b %0d",
                        $time, e.out_byte, e.last, e.archive_done, e.status,
                        rsp_tdata, rsp_tlast, rsp_tuser[0], rsp_tuser[2:1]);
               errors++;
            end
         end
      end
   end

   int quiet_cycles = 0;
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 5000) begin
         $display("%0t: watchdog expired, %0d bytes outstanding", $time, archive_q.size());
         $display("FAILED: results differ");
         $finish;
      end
   end

   initial begin
      repeat (10) @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_random_entries(20, 0, 0, 1'b0);
      test_random_entries(20, 70, 0, 1'b1);
      test_random_entries(20, 0, 70, 1'b0);
      test_random_entries(20, 9, 9, 1'b0);
      test_close_entry();
      test_trailer();
      wait_drained();
      repeat (50) @(posedge clock);
      $display("Covered %0d requests (%0d rejected), %0d entries, %0d bytes checked,",
               n_requests, n_rejects, n_entries, n_checked);
      $display("including empty entries, rejects and the full directory and end records.");
      if (errors == 0 && archive_q.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
